>>> src/ffsa_pkg.sv
// Shared types and constants for the first-fit segment allocator.
// Used by ffsa_ctrl, ffsa_dp and first_fit_segment_allocator; depends on nothing.
package ffsa_pkg;

    // Memory size in units and the derived widths.
    localparam int MEM_UNITS = 128;
    localparam int CW        = 8;
    localparam int AW        = $clog2(MEM_UNITS);
    localparam int OWN_W     = 5;
    localparam int SIZE_W    = 8;
    localparam int BASE_W    = 7;

    // Request opcodes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    // One table entry.
    typedef struct packed {
        logic             hole;
        logic [OWN_W-1:0] owner;
        logic [CW-1:0]    len;
    } seg_t;

    // Micro-operations the controller issues to the datapath.
    typedef enum logic [4:0] {
        C_NOP,
        C_LOAD,
        C_SCAN_RD,
        C_SCAN_NEXT,
        C_FIT_EXACT,
        C_FIT_SPLIT,
        C_SHUP_RD,
        C_SHUP_WR,
        C_SPLIT_BLK,
        C_SPLIT_HOLE,
        C_CMP_START,
        C_CMP_RD,
        C_CMP_EV,
        C_CMP_BLK,
        C_CMP_HOLE,
        C_REL_HIT,
        C_NEXT_RD,
        C_NEXT_EV,
        C_MERGE,
        C_SHDN_RD,
        C_SHDN_WR,
        C_SHDN_END,
        C_FINISH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        status_t code;
    } cmd_t;

    // Status flags the datapath reports back.
    typedef struct packed {
        logic op_rel;
        logic too_big;
        logic at_end;
        logic hit;
        logic fit_exact;
        logic shup_done;
        logic free_exact;
        logic has_next;
        logic shdn_done;
    } sts_t;

endpackage

>>> src/ffsa_dp.sv
// Datapath of the allocator: segment table memory, counters and result registers.
// Depends on ffsa_pkg; driven by ffsa_ctrl through cmd_t and reporting sts_t.
module ffsa_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ffsa_pkg::cmd_t          cmd,
    output ffsa_pkg::sts_t          sts,
    input  logic                    op,
    input  logic [4:0]              owner,
    input  logic [7:0]              req_size,
    output logic                    done,
    output logic [1:0]              status,
    output logic [6:0]              base,
    output logic [7:0]              free_units,
    output logic [7:0]              segment_total
);
    import ffsa_pkg::*;

    seg_t             mem [MEM_UNITS];
    seg_t             rd_data_reg;
    logic             op_reg;
    logic [OWN_W-1:0] own_reg;
    logic [CW-1:0]    size_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    free_reg, free_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    wptr_reg, wptr_next;
    logic [CW-1:0]    start_reg, start_next;
    logic [CW-1:0]    hit_len_reg, hit_len_next;
    logic             prev_hole_reg, prev_hole_next;
    logic [CW-1:0]    prev_len_reg, prev_len_next;
    logic             next_hole_reg, next_hole_next;
    logic [CW-1:0]    next_len_reg, next_len_next;
    logic [1:0]       dist_reg, dist_next;
    logic [BASE_W-1:0] base_reg, base_next;
    status_t          status_reg, status_next;
    logic             done_reg;
    logic             init_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    seg_t             wr_data;
    logic [CW-1:0]    merge_len;

    // Status flags for the controller.
    always_comb
    begin
        sts.op_rel     = op_reg;
        sts.too_big    = (size_reg == '0) || (size_reg > free_reg);
        sts.at_end     = (idx_reg == cnt_reg);
        sts.hit        = op_reg ? (!rd_data_reg.hole && rd_data_reg.owner == own_reg)
                                : (rd_data_reg.hole && rd_data_reg.len >= size_reg);
        sts.fit_exact  = (rd_data_reg.len == size_reg);
        sts.shup_done  = (wptr_reg == idx_reg);
        sts.free_exact = (free_reg == size_reg);
        sts.has_next   = (CW'(idx_reg + CW'(1)) < cnt_reg);
        sts.shdn_done  = (wptr_reg == cnt_reg) || (dist_reg == 2'd0);
    end

    // Merged hole length on release.
    always_comb
    begin
        merge_len = hit_len_reg;
        if (prev_hole_reg)
        begin
            merge_len = CW'(merge_len + prev_len_reg);
        end
        if (next_hole_reg)
        begin
            merge_len = CW'(merge_len + next_len_reg);
        end
    end

    // Next-state logic per micro-operation.
    always_comb
    begin
        cnt_next       = cnt_reg;
        free_next      = free_reg;
        idx_next       = idx_reg;
        wptr_next      = wptr_reg;
        start_next     = start_reg;
        hit_len_next   = hit_len_reg;
        prev_hole_next = prev_hole_reg;
        prev_len_next  = prev_len_reg;
        next_hole_next = next_hole_reg;
        next_len_next  = next_len_reg;
        dist_next      = dist_reg;
        base_next      = base_reg;
        status_next    = status_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_data        = rd_data_reg;
        unique case (cmd.op)
            C_NOP:
            begin
            end
            C_LOAD:
            begin
                idx_next       = '0;
                wptr_next      = '0;
                start_next     = '0;
                prev_hole_next = 1'b0;
                prev_len_next  = '0;
                base_next      = '0;
            end
            C_SCAN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
            end
            C_SCAN_NEXT:
            begin
                start_next     = CW'(start_reg + rd_data_reg.len);
                prev_hole_next = rd_data_reg.hole;
                prev_len_next  = rd_data_reg.len;
                idx_next       = CW'(idx_reg + CW'(1));
            end
            C_FIT_EXACT:
            begin
                wr_en     = 1'b1;
                wr_addr   = idx_reg[AW-1:0];
                wr_data   = '{hole: 1'b0, owner: own_reg, len: size_reg};
                free_next = CW'(free_reg - size_reg);
                base_next = start_reg[BASE_W-1:0];
            end
            C_FIT_SPLIT:
            begin
                hit_len_next = rd_data_reg.len;
                base_next    = start_reg[BASE_W-1:0];
                wptr_next    = cnt_reg;
            end
            C_SHUP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(wptr_reg - CW'(1));
            end
            C_SHUP_WR:
            begin
                wr_en     = 1'b1;
                wr_addr   = wptr_reg[AW-1:0];
                wptr_next = CW'(wptr_reg - CW'(1));
            end
            C_SPLIT_BLK:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data = '{hole: 1'b0, owner: own_reg, len: size_reg};
            end
            C_SPLIT_HOLE:
            begin
                wr_en     = 1'b1;
                wr_addr   = AW'(idx_reg + CW'(1));
                wr_data   = '{hole: 1'b1, owner: '0, len: CW'(hit_len_reg - size_reg)};
                cnt_next  = CW'(cnt_reg + CW'(1));
                free_next = CW'(free_reg - size_reg);
            end
            C_CMP_START:
            begin
                idx_next  = '0;
                wptr_next = '0;
            end
            C_CMP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
            end
            C_CMP_EV:
            begin
                idx_next = CW'(idx_reg + CW'(1));
                if (!rd_data_reg.hole)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = wptr_reg[AW-1:0];
                    wptr_next = CW'(wptr_reg + CW'(1));
                end
            end
            C_CMP_BLK:
            begin
                wr_en     = 1'b1;
                wr_addr   = wptr_reg[AW-1:0];
                wr_data   = '{hole: 1'b0, owner: own_reg, len: size_reg};
                base_next = BASE_W'(CW'(MEM_UNITS) - free_reg);
                if (free_reg == size_reg)
                begin
                    cnt_next  = CW'(wptr_reg + CW'(1));
                    free_next = '0;
                end
            end
            C_CMP_HOLE:
            begin
                wr_en     = 1'b1;
                wr_addr   = AW'(wptr_reg + CW'(1));
                wr_data   = '{hole: 1'b1, owner: '0, len: CW'(free_reg - size_reg)};
                cnt_next  = CW'(wptr_reg + CW'(2));
                free_next = CW'(free_reg - size_reg);
            end
            C_REL_HIT:
            begin
                hit_len_next   = rd_data_reg.len;
                base_next      = start_reg[BASE_W-1:0];
                free_next      = CW'(free_reg + rd_data_reg.len);
                next_hole_next = 1'b0;
                next_len_next  = '0;
            end
            C_NEXT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg + CW'(1));
            end
            C_NEXT_EV:
            begin
                next_hole_next = rd_data_reg.hole;
                next_len_next  = rd_data_reg.len;
            end
            C_MERGE:
            begin
                wr_en     = 1'b1;
                wr_addr   = prev_hole_reg ? AW'(idx_reg - CW'(1)) : idx_reg[AW-1:0];
                wr_data   = '{hole: 1'b1, owner: '0, len: merge_len};
                dist_next = {1'b0, prev_hole_reg} + {1'b0, next_hole_reg};
                wptr_next = CW'(idx_reg + CW'(1) + CW'(next_hole_reg));
            end
            C_SHDN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = wptr_reg[AW-1:0];
            end
            C_SHDN_WR:
            begin
                wr_en     = 1'b1;
                wr_addr   = AW'(wptr_reg - CW'(dist_reg));
                wptr_next = CW'(wptr_reg + CW'(1));
            end
            C_SHDN_END:
            begin
                cnt_next = CW'(cnt_reg - CW'(dist_reg));
            end
            C_FINISH:
            begin
                status_next = cmd.code;
            end
            default:
            begin
            end
        endcase
        // Entry zero is loaded with the full-size hole while init_reg is set.
        if (init_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{hole: 1'b1, owner: '0, len: CW'(MEM_UNITS)};
        end
    end

    // Segment table memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.op == C_LOAD)
        begin
            op_reg   <= op;
            own_reg  <= owner;
            size_reg <= req_size;
        end
    end

    // Working registers without reset.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        wptr_reg      <= wptr_next;
        start_reg     <= start_next;
        hit_len_reg   <= hit_len_next;
        prev_hole_reg <= prev_hole_next;
        prev_len_reg  <= prev_len_next;
        next_hole_reg <= next_hole_next;
        next_len_reg  <= next_len_next;
        dist_reg      <= dist_next;
        base_reg      <= base_next;
        status_reg    <= status_next;
    end

    // Table counters and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= CW'(1);
            free_reg <= CW'(MEM_UNITS);
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            free_reg <= free_next;
            done_reg <= (cmd.op == C_FINISH);
        end
    end

    // Entry zero is written with the full hole on every clock in reset and on the
    // first clock after release; the table is only read below cnt_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b1;
        end
        else
        begin
            init_reg <= 1'b0;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign base          = base_reg;
    assign free_units    = free_reg;
    assign segment_total = cnt_reg;

    // Free space never exceeds the memory size.
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CW'(MEM_UNITS))
        else $error("free space above memory size");

    // The table always holds between one and MEM_UNITS segments.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 && cnt_reg <= CW'(MEM_UNITS))
        else $error("segment count out of range");

    // A result is shown for one cycle only.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held");

    // Writes stay inside the table plus one new slot.
    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !init_reg |-> CW'(wr_addr) <= cnt_reg)
        else $error("table write beyond end");

endmodule

>>> src/ffsa_ctrl.sv
// Controller of the allocator: sequences scan, shift, compaction and merge steps.
// Depends on ffsa_pkg; drives ffsa_dp through cmd_t and reads sts_t.
module ffsa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ffsa_pkg::sts_t sts,
    output ffsa_pkg::cmd_t cmd
);
    import ffsa_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_CHECK     = 18'h00002,
        S_SCAN_RD   = 18'h00004,
        S_SCAN_EV   = 18'h00008,
        S_SHUP_RD   = 18'h00010,
        S_SHUP_WR   = 18'h00020,
        S_SPLIT_BLK = 18'h00040,
        S_SPLIT_HL  = 18'h00080,
        S_CMP_RD    = 18'h00100,
        S_CMP_EV    = 18'h00200,
        S_CMP_BLK   = 18'h00400,
        S_CMP_HOLE  = 18'h00800,
        S_REL_NRD   = 18'h01000,
        S_REL_NEV   = 18'h02000,
        S_MERGE     = 18'h04000,
        S_SHDN_RD   = 18'h08000,
        S_SHDN_WR   = 18'h10000,
        S_DONE      = 18'h20000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = C_NOP;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = C_LOAD;
                    code_next  = ST_OK;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.op_rel == OP_ALLOC && sts.too_big)
                begin
                    code_next  = ST_NOSPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.at_end)
                begin
                    if (sts.op_rel == OP_ALLOC)
                    begin
                        cmd.op     = C_CMP_START;
                        state_next = S_CMP_RD;
                    end
                    else
                    begin
                        code_next  = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.op     = C_SCAN_RD;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (!sts.hit)
                begin
                    cmd.op     = C_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
                else if (sts.op_rel == OP_RELEASE)
                begin
                    cmd.op     = C_REL_HIT;
                    state_next = S_REL_NRD;
                end
                else if (sts.fit_exact)
                begin
                    cmd.op     = C_FIT_EXACT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = C_FIT_SPLIT;
                    state_next = S_SHUP_RD;
                end
            end
            S_SHUP_RD:
            begin
                if (sts.shup_done)
                begin
                    state_next = S_SPLIT_BLK;
                end
                else
                begin
                    cmd.op     = C_SHUP_RD;
                    state_next = S_SHUP_WR;
                end
            end
            S_SHUP_WR:
            begin
                cmd.op     = C_SHUP_WR;
                state_next = S_SHUP_RD;
            end
            S_SPLIT_BLK:
            begin
                cmd.op     = C_SPLIT_BLK;
                state_next = S_SPLIT_HL;
            end
            S_SPLIT_HL:
            begin
                cmd.op     = C_SPLIT_HOLE;
                state_next = S_DONE;
            end
            S_CMP_RD:
            begin
                if (sts.at_end)
                begin
                    state_next = S_CMP_BLK;
                end
                else
                begin
                    cmd.op     = C_CMP_RD;
                    state_next = S_CMP_EV;
                end
            end
            S_CMP_EV:
            begin
                cmd.op     = C_CMP_EV;
                state_next = S_CMP_RD;
            end
            S_CMP_BLK:
            begin
                cmd.op     = C_CMP_BLK;
                state_next = sts.free_exact ? S_DONE : S_CMP_HOLE;
            end
            S_CMP_HOLE:
            begin
                cmd.op     = C_CMP_HOLE;
                state_next = S_DONE;
            end
            S_REL_NRD:
            begin
                if (sts.has_next)
                begin
                    cmd.op     = C_NEXT_RD;
                    state_next = S_REL_NEV;
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end
            S_REL_NEV:
            begin
                cmd.op     = C_NEXT_EV;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.op     = C_MERGE;
                state_next = S_SHDN_RD;
            end
            S_SHDN_RD:
            begin
                if (sts.shdn_done)
                begin
                    cmd.op     = C_SHDN_END;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = C_SHDN_RD;
                    state_next = S_SHDN_WR;
                end
            end
            S_SHDN_WR:
            begin
                cmd.op     = C_SHDN_WR;
                state_next = S_SHDN_RD;
            end
            S_DONE:
            begin
                cmd.op     = C_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Exactly one state bit is set.
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");

    // An accepted request leaves the idle state at once.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but controller idle");

    // Finishing always returns to idle.
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE)
        else $error("finish did not return to idle");

endmodule

>>> src/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator.
// Depends on ffsa_pkg, ffsa_ctrl and ffsa_dp.
//
//  Channel  | Signals                                    | Handshake
//  ---------+--------------------------------------------+---------------------------------
//  request  | op, owner, req_size                        | taken when start && !busy
//  result   | status, base, free_units, segment_total    | valid for one cycle with done
//
// A request reads the table entry by entry in the scan, then moves entries one at a time
// for a split, merge or compaction, each move a read and then a write, and ends with checks,
// end tests, final writes and the result register. The worst case is a full scan followed
// by compaction; a rejected allocate skips the scan. The segment table has one read and one
// write per cycle, which paces the scan and the moves.
// After reset the table holds one hole of MEM_UNITS units; no clearing pass is needed.
// The result cannot be stalled; free_units and segment_total stay valid while idle.
module first_fit_segment_allocator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       op,
    input  logic [4:0] owner,
    input  logic [7:0] req_size,
    output logic       done,
    output logic [1:0] status,
    output logic [6:0] base,
    output logic [7:0] free_units,
    output logic [7:0] segment_total
);
    import ffsa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    ffsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Table and arithmetic.
    ffsa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .owner         (owner),
        .req_size      (req_size),
        .done          (done),
        .status        (status),
        .base          (base),
        .free_units    (free_units),
        .segment_total (segment_total)
    );

endmodule
